[src/gsc_pkg.sv]
`timescale 1ns / 1ps
package gsc_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 20;
   localparam int ADC_MAX_W  = 16;
   localparam int RES_W      = 24;
   localparam int SUM_W      = 30;
   localparam int DVD_W      = 48;
   localparam int DVS_W      = 24;
   localparam int PPM_W      = 14;
   localparam int GAS_COUNT  = 6;

   localparam logic [RES_W-1:0] R_MAX   = '1;
   localparam logic [SUM_W-1:0] SUM_MAX = '1;
   localparam logic [PPM_W-1:0] PPM_MAX = 14'd10000;
   localparam longint LOG2_10_Q16 = 217706;

   localparam logic [CSR_ADDR_W-1:0] CSR_DISCONNECT = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PREHEAT    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_INTERVAL   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SAMPLES    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOAD       = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_FACTOR     = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAS        = 3'd6;

   typedef enum logic [1:0] {
      MODE_NC      = 2'd0,
      MODE_PREHEAT = 2'd1,
      MODE_CAL     = 2'd2,
      MODE_READY   = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      S_IDLE, S_RS_DIV, S_ACC, S_AVG_DIV, S_RO_DIV, S_EVAL, S_RATIO_DIV,
      S_PPM, S_NORM, S_LOG, S_MUL, S_EXP0, S_EXP, S_FIN, S_OUT
   } back_state_type;

   typedef struct packed {
      logic [15:0] disconnect;
      logic [19:0] preheat;
      logic [15:0] interval;
      logic [6:0]  samples;
      logic [15:0] load;
      logic [15:0] factor;
      logic [2:0]  gas;
   } cfg_type;

   typedef struct packed {
      logic [ADC_MAX_W-1:0] adc;
      logic                 disc;
   } q_item_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             ratio_valid;
      logic [RES_W-1:0] ratio;
      logic [PPM_W-1:0] ppm;
   } res_type;

   function automatic longint milli_to_q16(longint m);
      return (m * 65536 + 500) / 1000;
   endfunction

   // a * log2(10), Q.32
   function automatic logic signed [DVD_W-1:0] gas_a32(logic [2:0] g);
      longint a;
      unique case (g)
         3'd0:    a = milli_to_q16(3541);
         3'd1:    a = milli_to_q16(2802);
         3'd2:    a = milli_to_q16(5692);
         3'd3:    a = milli_to_q16(14725);
         3'd4:    a = milli_to_q16(12054);
         3'd5:    a = milli_to_q16(7744);
         default: a = 0;
      endcase
      return DVD_W'(a * LOG2_10_Q16);
   endfunction

   function automatic logic signed [21:0] gas_b16(logic [2:0] g);
      longint b;
      unique case (g)
         3'd0:    b = milli_to_q16(3674);
         3'd1:    b = milli_to_q16(3267);
         3'd2:    b = milli_to_q16(6336);
         3'd3:    b = milli_to_q16(19804);
         3'd4:    b = milli_to_q16(16633);
         3'd5:    b = milli_to_q16(9895);
         default: b = 0;
      endcase
      return 22'(b);
   endfunction

   function automatic logic [63:0] isqrt64(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bt;
      logic [63:0] rem;
      res = '0;
      bt  = 64'd1 << 62;
      rem = v;
      for (int j = 0; j < 32; j++) begin
         if (rem >= res + bt) begin
            rem = rem - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   // entry j is 2^(2^-(j+1)) in Q1.30, built by repeated integer square roots
   function automatic logic [15:0][31:0] exp2_roots();
      logic [15:0][31:0] tab;
      logic [63:0]       r;
      r = 64'd1 << 31;
      for (int j = 0; j < 16; j++) begin
         r = isqrt64(r << 30);
         tab[j] = r[31:0];
      end
      return tab;
   endfunction

endpackage

[src/gsc_front.sv]
`timescale 1ns / 1ps
module gsc_front #(
   parameter int ADC_BITS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ADC_BITS-1:0]  req_adc_sample,
   input  gsc_pkg::cfg_type     cfg,
   output logic                 q_valid,
   output gsc_pkg::q_item_type  q_data,
   input  logic                 q_pop
);

   gsc_pkg::q_item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   gsc_pkg::q_item_type item;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_data    = entry_ff[rd_ptr_ff];

   // classify the word on entry: disconnected or live
   always_comb begin
      item.adc  = gsc_pkg::ADC_MAX_W'(req_adc_sample);
      item.disc = (req_adc_sample >= cfg.disconnect[ADC_BITS-1:0]);
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

[src/gsc_div.sv]
`timescale 1ns / 1ps
module gsc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [gsc_pkg::DVD_W-1:0]   dividend,
   input  logic [gsc_pkg::DVS_W-1:0]   divisor,
   output logic                        done,
   output logic [gsc_pkg::DVD_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(gsc_pkg::DVD_W);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [gsc_pkg::DVD_W-1:0]   quo_ff, quo_in;
   logic [gsc_pkg::DVS_W-1:0]   rem_ff, rem_in;
   logic [gsc_pkg::DVS_W-1:0]   dvs_ff, dvs_in;
   logic [gsc_pkg::DVS_W:0]     trial;
   logic                        fits;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // restoring division, one quotient bit a cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[gsc_pkg::DVD_W-1]};
      fits    = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? gsc_pkg::DVS_W'(trial - {1'b0, dvs_ff})
                       : trial[gsc_pkg::DVS_W-1:0];
         quo_in = {quo_ff[gsc_pkg::DVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(gsc_pkg::DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

[src/gsc_back.sv]
`timescale 1ns / 1ps
module gsc_back #(
   parameter int MAX_SAMPLES = 64,
   parameter int ADC_BITS    = 10,
   parameter int TIMER_BITS  = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gsc_pkg::cfg_type     cfg,
   input  logic                 q_valid,
   input  gsc_pkg::q_item_type  q_data,
   output logic                 q_pop,
   output logic                 res_valid,
   input  logic                 res_ready,
   output gsc_pkg::res_type     res
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam logic [ADC_BITS-1:0] ADC_FULL = '1;
   localparam logic [15:0][31:0] ROOTS = gsc_pkg::exp2_roots();
   localparam logic signed [gsc_pkg::DVD_W-1:0] E_LIMIT = 48'sh000E_0000_0000;

   gsc_pkg::back_state_type state_ff, state_in;
   gsc_pkg::mode_type       mode_ff, mode_in;
   logic [TIMER_BITS-1:0]        elapsed_ff, elapsed_in;
   logic [ADC_BITS-1:0]          ref_ff, ref_in;
   logic [gsc_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]             taken_ff, taken_in;
   logic [gsc_pkg::RES_W-1:0]    ro_ff, ro_in;
   logic [gsc_pkg::RES_W-1:0]    rs_ff, rs_in;
   logic                         known_ff, known_in;
   logic [gsc_pkg::RES_W-1:0]    sample_ff, sample_in;
   logic [gsc_pkg::RES_W-1:0]    ratio_ff, ratio_in;
   logic [31:0]                  m_ff, m_in;
   logic [4:0]                   p_ff, p_in;
   logic [15:0]                  frac_ff, frac_in;
   logic [3:0]                   cnt_ff, cnt_in;
   logic signed [gsc_pkg::DVD_W-1:0] prod_ff, prod_in;
   logic [3:0]                   k_ff, k_in;
   logic [15:0]                  f_ff, f_in;
   logic [gsc_pkg::PPM_W-1:0]    ppm_ff, ppm_in;

   logic                         div_start, div_done;
   logic [gsc_pkg::DVD_W-1:0]    div_dvd, div_q;
   logic [gsc_pkg::DVS_W-1:0]    div_dvs;

   logic [TIMER_BITS-1:0]        el;
   logic [ADC_BITS-1:0]          adc_new, diff;
   logic [CNT_W-1:0]             n_eff, taken_nx;
   logic [gsc_pkg::SUM_W:0]      sum_wide;
   logic [gsc_pkg::SUM_W-1:0]    sum_sat;
   logic [gsc_pkg::RES_W-1:0]    q_sat;
   logic [63:0]                  sq, mr;
   logic [33:0]                  sq_t;
   logic [5:0]                   p_m16;
   logic signed [21:0]           log_q16;
   logic signed [43:0]           blog;
   logic signed [gsc_pkg::DVD_W-1:0] e32;
   logic [44:0]                  shifted;
   logic [14:0]                  ppm_raw;
   logic [15:0]                  factor_eff;

   gsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   assign res.status      = mode_ff;
   assign res.ratio_valid = (mode_ff == gsc_pkg::MODE_READY) && known_ff;
   assign res.ratio       = ratio_ff;
   assign res.ppm         = ppm_ff;

   always_comb begin
      el       = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
      adc_new  = q_data.adc[ADC_BITS-1:0];
      diff     = (adc_new > ref_ff) ? adc_new - ref_ff : ref_ff - adc_new;
      if (cfg.samples == 7'd0) begin
         n_eff = CNT_W'(1);
      end else if (9'(cfg.samples) > 9'(MAX_SAMPLES)) begin
         n_eff = CNT_W'(MAX_SAMPLES);
      end else begin
         n_eff = CNT_W'(cfg.samples);
      end
      taken_nx   = taken_ff + 1'b1;
      sum_wide   = {1'b0, sum_ff} + (gsc_pkg::SUM_W + 1)'(sample_ff);
      sum_sat    = sum_wide[gsc_pkg::SUM_W] ? gsc_pkg::SUM_MAX
                                            : sum_wide[gsc_pkg::SUM_W-1:0];
      q_sat      = (|div_q[gsc_pkg::DVD_W-1:gsc_pkg::RES_W]) ? gsc_pkg::R_MAX
                                                             : div_q[gsc_pkg::RES_W-1:0];
      factor_eff = (cfg.factor == 16'd0) ? 16'd1 : cfg.factor;
      sq         = 64'(m_ff) * 64'(m_ff);
      sq_t       = sq[63:30];
      mr         = 64'(m_ff) * 64'(ROOTS[cnt_ff]);
      p_m16      = 6'(p_ff) - 6'd16;
      log_q16    = {p_m16, frac_ff};
      blog       = 44'(gsc_pkg::gas_b16(cfg.gas)) * 44'(log_q16);
      e32        = gsc_pkg::gas_a32(cfg.gas) - prod_ff;
      shifted    = 45'(m_ff) << k_ff;
      ppm_raw    = shifted[44:30];

      state_in  = state_ff;
      mode_in   = mode_ff;
      elapsed_in = elapsed_ff;
      ref_in    = ref_ff;
      sum_in    = sum_ff;
      taken_in  = taken_ff;
      ro_in     = ro_ff;
      rs_in     = rs_ff;
      known_in  = known_ff;
      sample_in = sample_ff;
      ratio_in  = ratio_ff;
      m_in      = m_ff;
      p_in      = p_ff;
      frac_in   = frac_ff;
      cnt_in    = cnt_ff;
      prod_in   = prod_ff;
      k_in      = k_ff;
      f_in      = f_ff;
      ppm_in    = ppm_ff;
      div_start = 1'b0;
      div_dvd   = '0;
      div_dvs   = '0;
      q_pop     = 1'b0;
      res_valid = 1'b0;

      unique case (state_ff)
         gsc_pkg::S_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               elapsed_in = el;
               state_in   = gsc_pkg::S_EVAL;
               if (q_data.disc) begin
                  mode_in = gsc_pkg::MODE_NC;
               end else begin
                  unique case (mode_ff)
                     gsc_pkg::MODE_NC: begin
                        mode_in    = gsc_pkg::MODE_PREHEAT;
                        elapsed_in = '0;
                        ref_in     = adc_new;
                     end
                     gsc_pkg::MODE_PREHEAT: begin
                        if (diff > ADC_BITS'(1)) begin
                           elapsed_in = '0;
                           ref_in     = adc_new;
                        end else if (32'(el) >= 32'(cfg.preheat)) begin
                           mode_in    = gsc_pkg::MODE_CAL;
                           elapsed_in = '0;
                           sum_in     = '0;
                           taken_in   = '0;
                        end
                     end
                     default: begin
                        if (32'(el) >= 32'(cfg.interval)) begin
                           elapsed_in = '0;
                           if (adc_new == '0) begin
                              sample_in = gsc_pkg::R_MAX;
                              state_in  = gsc_pkg::S_ACC;
                           end else if (adc_new >= ADC_FULL) begin
                              sample_in = '0;
                              state_in  = gsc_pkg::S_ACC;
                           end else begin
                              div_start = 1'b1;
                              div_dvd   = gsc_pkg::DVD_W'(cfg.load)
                                          * gsc_pkg::DVD_W'(ADC_FULL - adc_new);
                              div_dvs   = gsc_pkg::DVS_W'(adc_new);
                              state_in  = gsc_pkg::S_RS_DIV;
                           end
                        end
                     end
                  endcase
               end
            end
         end
         gsc_pkg::S_RS_DIV: begin
            if (div_done) begin
               sample_in = q_sat;
               state_in  = gsc_pkg::S_ACC;
            end
         end
         gsc_pkg::S_ACC: begin
            if (taken_nx < n_eff) begin
               sum_in   = sum_sat;
               taken_in = taken_nx;
               state_in = gsc_pkg::S_EVAL;
            end else begin
               div_start = 1'b1;
               div_dvd   = gsc_pkg::DVD_W'(sum_sat);
               div_dvs   = gsc_pkg::DVS_W'(n_eff);
               sum_in    = '0;
               taken_in  = '0;
               state_in  = gsc_pkg::S_AVG_DIV;
            end
         end
         gsc_pkg::S_AVG_DIV: begin
            if (div_done) begin
               if (mode_ff == gsc_pkg::MODE_CAL) begin
                  div_start = 1'b1;
                  div_dvd   = gsc_pkg::DVD_W'({div_q[gsc_pkg::SUM_W-1:0], 8'd0});
                  div_dvs   = gsc_pkg::DVS_W'(factor_eff);
                  state_in  = gsc_pkg::S_RO_DIV;
               end else begin
                  rs_in    = div_q[gsc_pkg::RES_W-1:0];
                  known_in = 1'b1;
                  state_in = gsc_pkg::S_EVAL;
               end
            end
         end
         gsc_pkg::S_RO_DIV: begin
            if (div_done) begin
               ro_in    = q_sat;
               known_in = 1'b0;
               mode_in  = gsc_pkg::MODE_READY;
               state_in = gsc_pkg::S_EVAL;
            end
         end
         gsc_pkg::S_EVAL: begin
            if (mode_ff == gsc_pkg::MODE_READY && known_ff) begin
               if (ro_ff == '0) begin
                  ratio_in = gsc_pkg::R_MAX;
                  state_in = gsc_pkg::S_PPM;
               end else begin
                  div_start = 1'b1;
                  div_dvd   = gsc_pkg::DVD_W'({rs_ff, 16'd0});
                  div_dvs   = ro_ff;
                  state_in  = gsc_pkg::S_RATIO_DIV;
               end
            end else begin
               ratio_in = '0;
               ppm_in   = '0;
               state_in = gsc_pkg::S_OUT;
            end
         end
         gsc_pkg::S_RATIO_DIV: begin
            if (div_done) begin
               ratio_in = q_sat;
               state_in = gsc_pkg::S_PPM;
            end
         end
         gsc_pkg::S_PPM: begin
            if (32'(cfg.gas) >= 32'(gsc_pkg::GAS_COUNT)) begin
               ppm_in   = '0;
               state_in = gsc_pkg::S_OUT;
            end else if (ratio_ff == '0) begin
               ppm_in   = gsc_pkg::PPM_MAX;
               state_in = gsc_pkg::S_OUT;
            end else begin
               m_in     = {1'b0, ratio_ff, 7'd0};
               p_in     = 5'd23;
               state_in = gsc_pkg::S_NORM;
            end
         end
         gsc_pkg::S_NORM: begin
            // bring the leading one up to bit 30
            if (p_ff != 5'd0 && !m_ff[30]) begin
               m_in = {m_ff[30:0], 1'b0};
               p_in = p_ff - 1'b1;
            end else begin
               cnt_in   = '0;
               frac_in  = '0;
               state_in = gsc_pkg::S_LOG;
            end
         end
         gsc_pkg::S_LOG: begin
            if (sq_t[31]) begin
               m_in    = sq_t[32:1];
               frac_in = {frac_ff[14:0], 1'b1};
            end else begin
               m_in    = sq_t[31:0];
               frac_in = {frac_ff[14:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd15) begin
               state_in = gsc_pkg::S_MUL;
            end
         end
         gsc_pkg::S_MUL: begin
            prod_in  = gsc_pkg::DVD_W'(blog);
            state_in = gsc_pkg::S_EXP0;
         end
         gsc_pkg::S_EXP0: begin
            if (e32 < 0) begin
               ppm_in   = '0;
               state_in = gsc_pkg::S_OUT;
            end else if (e32 >= E_LIMIT) begin
               ppm_in   = gsc_pkg::PPM_MAX;
               state_in = gsc_pkg::S_OUT;
            end else begin
               k_in     = e32[35:32];
               f_in     = e32[31:16];
               m_in     = 32'd1 << 30;
               cnt_in   = '0;
               state_in = gsc_pkg::S_EXP;
            end
         end
         gsc_pkg::S_EXP: begin
            if (f_ff[4'd15 - cnt_ff]) begin
               m_in = mr[61:30];
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd15) begin
               state_in = gsc_pkg::S_FIN;
            end
         end
         gsc_pkg::S_FIN: begin
            ppm_in   = (ppm_raw > 15'(gsc_pkg::PPM_MAX)) ? gsc_pkg::PPM_MAX
                                                         : ppm_raw[gsc_pkg::PPM_W-1:0];
            state_in = gsc_pkg::S_OUT;
         end
         gsc_pkg::S_OUT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = gsc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = gsc_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= gsc_pkg::S_IDLE;
         mode_ff    <= gsc_pkg::MODE_NC;
         elapsed_ff <= '0;
         ref_ff     <= '0;
         sum_ff     <= '0;
         taken_ff   <= '0;
         ro_ff      <= '0;
         rs_ff      <= '0;
         known_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         mode_ff    <= mode_in;
         elapsed_ff <= elapsed_in;
         ref_ff     <= ref_in;
         sum_ff     <= sum_in;
         taken_ff   <= taken_in;
         ro_ff      <= ro_in;
         rs_ff      <= rs_in;
         known_ff   <= known_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      ratio_ff  <= ratio_in;
      m_ff      <= m_in;
      p_ff      <= p_in;
      frac_ff   <= frac_in;
      cnt_ff    <= cnt_in;
      prod_ff   <= prod_in;
      k_ff      <= k_in;
      f_ff      <= f_in;
      ppm_ff    <= ppm_in;
   end

endmodule

[src/gas_sensor_calibrate_and_ppm.sv]
`timescale 1ns / 1ps
// gas sensor calibration and concentration
// req channel: one word per millisecond tick, req_adc_sample is the raw reading;
//   a word is taken when req_valid is high and req_stall is low
// rsp channel: one word per request with status, ratio valid flag, Rs/Ro ratio
//   (Q8.16) and ppm of the selected gas; taken when rsp_valid and !rsp_stall
// csr channel: csr_addr selects a register, csr_wdata is written when csr_valid
//   and csr_ready are high; write only while no request is in flight
// a two-word queue sits in front of the sequencer, so the sender keeps going
//   while one word is being worked on and another waits
// work per word runs from the short path (no sample due, not ready) to the long
//   path (sample, average, ratio and curve on one tick); each of up to three
//   divisions runs in the shared bit-serial divider; the log2 and exp2 steps
//   each run a multiply loop, and the log2 step first normalizes its input
// one word is in the sequencer at a time; the next waits for its response
// a stalled response holds in the output register; the sequencer waits for it
//   to drain and the queue fills, then req_stall rises
// reset (synchronous) restores register defaults, sets status to not connected
//   and clears the timer, averages and resistances
module gas_sensor_calibrate_and_ppm #(
   parameter int MAX_SAMPLES = 64,
   parameter int ADC_BITS    = 10,
   parameter int TIMER_BITS  = 20
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ADC_BITS-1:0]                req_adc_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_ratio_valid,
   output logic [gsc_pkg::RES_W-1:0]          rsp_res_ratio,
   output logic [gsc_pkg::PPM_W-1:0]          rsp_gas_ppm,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gsc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [gsc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   gsc_pkg::cfg_type     cfg_ff, cfg_in;
   gsc_pkg::q_item_type  q_data;
   gsc_pkg::res_type     res, out_ff;
   logic                 q_valid, q_pop;
   logic                 res_valid, res_ready;
   logic                 out_valid_ff, out_valid_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_addr)
            gsc_pkg::CSR_DISCONNECT: cfg_in.disconnect = 16'(csr_wdata[ADC_BITS-1:0]);
            gsc_pkg::CSR_PREHEAT:    cfg_in.preheat    = csr_wdata;
            gsc_pkg::CSR_INTERVAL:   cfg_in.interval   = csr_wdata[15:0];
            gsc_pkg::CSR_SAMPLES:    cfg_in.samples    = csr_wdata[6:0];
            gsc_pkg::CSR_LOAD:       cfg_in.load       = csr_wdata[15:0];
            gsc_pkg::CSR_FACTOR:     cfg_in.factor     = csr_wdata[15:0];
            gsc_pkg::CSR_GAS:        cfg_in.gas        = csr_wdata[2:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.disconnect <= 16'd1003;
         cfg_ff.preheat    <= 20'd20000;
         cfg_ff.interval   <= 16'd50;
         cfg_ff.samples    <= 7'd5;
         cfg_ff.load       <= 16'd2560;
         cfg_ff.factor     <= 16'd2516;
         cfg_ff.gas        <= 3'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gsc_front #(
      .ADC_BITS (ADC_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_adc_sample (req_adc_sample),
      .cfg            (cfg_ff),
      .q_valid        (q_valid),
      .q_data         (q_data),
      .q_pop          (q_pop)
   );

   gsc_back #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .ADC_BITS    (ADC_BITS),
      .TIMER_BITS  (TIMER_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // output register
   assign res_ready = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (res_ready) begin
         out_valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_ratio_valid = out_ff.ratio_valid;
   assign rsp_res_ratio   = out_ff.ratio;
   assign rsp_gas_ppm     = out_ff.ppm;

endmodule

[src/gsc_checker.sv]
`timescale 1ns / 1ps
module gsc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [1:0]                 rsp_status,
   input logic                       rsp_ratio_valid,
   input logic [gsc_pkg::RES_W-1:0]  rsp_res_ratio,
   input logic [gsc_pkg::PPM_W-1:0]  rsp_gas_ppm
);

   localparam logic [1:0] STATUS_READY = 2'(gsc_pkg::MODE_READY);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_gas_ppm))
      else $error("stalled response word changed");

   a_valid_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ratio_valid |-> rsp_status == STATUS_READY)
      else $error("ratio flagged valid outside ready");

   a_zero_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ratio_valid |-> rsp_res_ratio == '0 && rsp_gas_ppm == '0)
      else $error("ratio or ppm nonzero while not valid");

   a_ppm_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_gas_ppm <= gsc_pkg::PPM_MAX)
      else $error("ppm above clamp");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind gas_sensor_calibrate_and_ppm gsc_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_ratio_valid (rsp_ratio_valid),
   .rsp_res_ratio   (rsp_res_ratio),
   .rsp_gas_ppm     (rsp_gas_ppm)
);
